// File: sv/ebiq_pkg.sv
// Shared types, codes, reset values and the quadrature table for the input qualifier.
package ebiq_pkg;

  // default parameter values
  localparam int TICK_WIDTH_DEF = 16;
  localparam int TIME_WIDTH_DEF = 32;

  // opcodes
  localparam logic [1:0] OP_PIN  = 2'd0;
  localparam logic [1:0] OP_POLL = 2'd1;
  localparam logic [1:0] OP_ACT  = 2'd2;
  localparam logic [1:0] OP_WOKE = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DETENT        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_DEAD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = 3'd4;
  localparam int CFG_DATA_W = 32;

  // configuration reset values
  localparam logic [31:0] SLEEP_TIMEOUT_RST = 32'd60000;
  localparam logic [3:0]  DETENT_RST        = 4'd4;
  localparam logic [15:0] SCROLL_DEAD_RST   = 16'd50;
  localparam logic [15:0] DEBOUNCE_RST      = 16'd50;
  localparam logic [15:0] LONG_PRESS_RST    = 16'd2000;

  localparam logic [1:0] PREV_AB_RST = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        pin_a;
    logic        pin_b;
    logic        click_level;
    logic        side_level;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic changed;
    logic scroll_down;
    logic scroll_up;
    logic enter;
    logic back;
    logic sleep_display;
    logic wake_display;
    logic power_off;
    logic woke_flag;
  } out_word_t;

  // quadrature step from {prev_a, prev_b, a, b}
  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

// File: sv/ebiq_if.sv
// Valid/ready channel interfaces for the input and result words.
interface ebiq_in_if;
  import ebiq_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ebiq_out_if;
  import ebiq_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/encoder_button_input_qualifier_top.sv
// Quadrature encoder and two-key input qualifier with idle-sleep control, top level.
//
// Usage:
//  - in_ch carries one command word per handshake: pin change, poll, activity or
//    woke-flag query (opcode), with encoder/key levels and a millisecond timestamp.
//  - out_ch returns exactly one result word per command word, in order.
//  - cfg_we/cfg_index/cfg_wdata write the five timing/detent registers; write only
//    while no command is in flight.
// Timing:
//  - A word accepted on in_ch sits in the input register, is processed
//    in one combinational pass, and its result is held in the result register.
//  - Throughput is one word per cycle unless out_ch stalls; the next command
//    sees the state left by the previous one; state and result register update together.
// Reset (rst_n low, synchronous): both channels empty, config at defaults,
//  encoder state 3, counters and timestamps zero, keys released, not started.
// Stall: while out_ch.ready is low the result holds; one more word can sit in
//  the input register, then in_ch.ready drops until the result is taken.
module encoder_button_input_qualifier_top #(
  parameter int TICK_WIDTH = ebiq_pkg::TICK_WIDTH_DEF,
  parameter int TIME_WIDTH = ebiq_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ebiq_in_if.sink                        in_ch,
  ebiq_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [ebiq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ebiq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ebiq_pkg::*;

  localparam int SW = TICK_WIDTH + 1;   // tick sum width
  localparam int AW = 5;                // detent remainder stays within +/-14
  localparam logic signed [TICK_WIDTH-1:0] TICK_MAX = {1'b0, {(TICK_WIDTH-1){1'b1}}};
  localparam logic signed [TICK_WIDTH-1:0] TICK_MIN = {1'b1, {(TICK_WIDTH-1){1'b0}}};

  // config registers
  logic [31:0] sleep_timeout_r;
  logic [3:0]  detent_r;
  logic [15:0] scroll_dead_r;
  logic [15:0] debounce_r;
  logic [15:0] long_press_r;

  // channel registers
  logic      s1_v_r;
  in_word_t  s1_word_r;
  logic      out_v_r;
  out_word_t out_word_r;
  logic      adv;

  // block state
  logic [1:0]                   prev_ab_r, prev_ab_nxt;
  logic signed [TICK_WIDTH-1:0] tick_r, tick_nxt;
  logic signed [AW-1:0]         accum_r, accum_nxt;
  logic [TIME_WIDTH-1:0]        last_scroll_r, last_scroll_nxt;
  logic [TIME_WIDTH-1:0]        last_act_r, last_act_nxt;
  logic [TIME_WIDTH-1:0]        last_click_r, last_click_nxt;
  logic [TIME_WIDTH-1:0]        last_side_r, last_side_nxt;
  logic [TIME_WIDTH-1:0]        side_start_r, side_start_nxt;
  logic sleeping_r, sleeping_nxt;
  logic woke_pending_r, woke_pending_nxt;
  logic started_r, started_nxt;
  logic prev_click_r, prev_click_nxt;
  logic prev_side_r, prev_side_nxt;
  logic side_valid_r, side_valid_nxt;
  logic power_fired_r, power_fired_nxt;
  out_word_t res;

  // handshake: stage 1 moves on when the result register is free or drains
  assign adv          = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || adv;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_word_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sleep_timeout_r <= SLEEP_TIMEOUT_RST;
      detent_r        <= DETENT_RST;
      scroll_dead_r   <= SCROLL_DEAD_RST;
      debounce_r      <= DEBOUNCE_RST;
      long_press_r    <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLEEP_TIMEOUT: sleep_timeout_r <= cfg_wdata;
        CFG_DETENT:        detent_r        <= cfg_wdata[3:0];
        CFG_SCROLL_DEAD:   scroll_dead_r   <= cfg_wdata[15:0];
        CFG_DEBOUNCE:      debounce_r      <= cfg_wdata[15:0];
        CFG_LONG_PRESS:    long_press_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // single processing pass over the registered command word
  always_comb begin
    logic [TIME_WIDTH-1:0]  now;
    logic [TIME_WIDTH-1:0]  el_act;
    logic [TIME_WIDTH-1:0]  el_scroll;
    logic [TIME_WIDTH-1:0]  el_click;
    logic [TIME_WIDTH-1:0]  el_side;
    logic [TIME_WIDTH-1:0]  el_hold;
    logic [3:0]             det;
    logic signed [SW-1:0]   det_s;
    logic signed [SW-1:0]   sum;
    logic signed [SW-1:0]   tsum;
    logic signed [1:0]      q;
    logic                   early;
    logic                   hit;

    prev_ab_nxt      = prev_ab_r;
    tick_nxt         = tick_r;
    accum_nxt        = accum_r;
    last_scroll_nxt  = last_scroll_r;
    last_act_nxt     = last_act_r;
    last_click_nxt   = last_click_r;
    last_side_nxt    = last_side_r;
    side_start_nxt   = side_start_r;
    sleeping_nxt     = sleeping_r;
    woke_pending_nxt = woke_pending_r;
    started_nxt      = started_r;
    prev_click_nxt   = prev_click_r;
    prev_side_nxt    = prev_side_r;
    side_valid_nxt   = side_valid_r;
    power_fired_nxt  = power_fired_r;
    res              = '0;

    now       = s1_word_r.now_ms[TIME_WIDTH-1:0];
    det       = (detent_r == 4'd0) ? 4'd1 : detent_r;
    det_s     = $signed(SW'(det));
    sum       = {{(SW-AW){accum_r[AW-1]}}, accum_r} + {tick_r[TICK_WIDTH-1], tick_r};
    hit       = (sum >= det_s) || (sum <= -det_s);
    q         = quad_step({prev_ab_r, s1_word_r.pin_a, s1_word_r.pin_b});
    tsum      = {tick_r[TICK_WIDTH-1], tick_r} + {{(SW-2){q[1]}}, q};
    early     = 1'b0;
    el_act    = '0;
    el_scroll = now - last_scroll_r;
    el_click  = now - last_click_r;
    el_side   = now - last_side_r;
    el_hold   = '0;

    case (s1_word_r.opcode)
      OP_PIN: begin
        if (started_r) begin
          // saturate at the signed tick range
          if (tsum[SW-1] != tsum[SW-2]) begin
            tick_nxt = tsum[SW-1] ? TICK_MIN : TICK_MAX;
          end else begin
            tick_nxt = tsum[TICK_WIDTH-1:0];
          end
          prev_ab_nxt = {s1_word_r.pin_a, s1_word_r.pin_b};
        end
      end
      OP_POLL: begin
        if (!started_r) begin
          last_act_nxt = now;
        end
        started_nxt = 1'b1;
        el_act = now - last_act_nxt;
        if (sleep_timeout_r != 32'd0 && !sleeping_r && 32'(el_act) >= sleep_timeout_r) begin
          sleeping_nxt      = 1'b1;
          res.sleep_display = 1'b1;
        end

        // detent folding with dead time
        tick_nxt = '0;
        if (hit) begin
          accum_nxt = '0;
          if (el_scroll >= TIME_WIDTH'(scroll_dead_r)) begin
            last_act_nxt    = now;
            last_scroll_nxt = now;
            if (sleeping_nxt) begin
              // wake-only event ends the poll
              sleeping_nxt     = 1'b0;
              woke_pending_nxt = 1'b1;
              res.wake_display = 1'b1;
              early            = 1'b1;
            end else begin
              res.changed = 1'b1;
              if (!sum[SW-1]) res.scroll_down = 1'b1;
              else res.scroll_up = 1'b1;
            end
          end
        end else begin
          accum_nxt = sum[AW-1:0];
        end

        if (!early) begin
          // click key falling edge
          if (!s1_word_r.click_level && prev_click_r && el_click > TIME_WIDTH'(debounce_r)) begin
            last_click_nxt = now;
            last_act_nxt   = now;
            if (!sleeping_nxt) begin
              res.changed = 1'b1;
              res.enter   = 1'b1;
            end else begin
              sleeping_nxt     = 1'b0;
              woke_pending_nxt = 1'b1;
              res.wake_display = 1'b1;
            end
          end
          prev_click_nxt = s1_word_r.click_level;

          // side key falling edge
          if (!s1_word_r.side_level && prev_side_r && el_side > TIME_WIDTH'(debounce_r)) begin
            last_side_nxt   = now;
            side_start_nxt  = now;
            side_valid_nxt  = 1'b1;
            power_fired_nxt = 1'b0;
            last_act_nxt    = now;
            if (!sleeping_nxt) begin
              res.changed = 1'b1;
              res.back    = 1'b1;
            end else begin
              sleeping_nxt     = 1'b0;
              woke_pending_nxt = 1'b1;
              res.wake_display = 1'b1;
            end
          end

          // long hold -> power off
          el_hold = now - side_start_nxt;
          if (!s1_word_r.side_level && !power_fired_nxt && side_valid_nxt &&
              el_hold >= TIME_WIDTH'(long_press_r)) begin
            power_fired_nxt = 1'b1;
            res.power_off   = 1'b1;
          end
          if (s1_word_r.side_level) begin
            side_valid_nxt  = 1'b0;
            power_fired_nxt = 1'b0;
          end
          prev_side_nxt = s1_word_r.side_level;
        end
      end
      OP_ACT: begin
        last_act_nxt = now;
        if (sleeping_r) begin
          sleeping_nxt     = 1'b0;
          res.wake_display = 1'b1;
        end
      end
      default: begin
        res.woke_flag    = woke_pending_r;
        woke_pending_nxt = 1'b0;
      end
    endcase
  end

  // control: valid flags and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
      prev_ab_r      <= PREV_AB_RST;
      tick_r         <= '0;
      accum_r        <= '0;
      last_scroll_r  <= '0;
      last_act_r     <= '0;
      last_click_r   <= '0;
      last_side_r    <= '0;
      side_start_r   <= '0;
      sleeping_r     <= 1'b0;
      woke_pending_r <= 1'b0;
      started_r      <= 1'b0;
      prev_click_r   <= 1'b1;
      prev_side_r    <= 1'b1;
      side_valid_r   <= 1'b0;
      power_fired_r  <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (adv) begin
        prev_ab_r      <= prev_ab_nxt;
        tick_r         <= tick_nxt;
        accum_r        <= accum_nxt;
        last_scroll_r  <= last_scroll_nxt;
        last_act_r     <= last_act_nxt;
        last_click_r   <= last_click_nxt;
        last_side_r    <= last_side_nxt;
        side_start_r   <= side_start_nxt;
        sleeping_r     <= sleeping_nxt;
        woke_pending_r <= woke_pending_nxt;
        started_r      <= started_nxt;
        prev_click_r   <= prev_click_nxt;
        prev_side_r    <= prev_side_nxt;
        side_valid_r   <= side_valid_nxt;
        power_fired_r  <= power_fired_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_word_r <= in_ch.data;
    end
    if (adv) begin
      out_word_r <= res;
    end
  end

endmodule

// File: test/ebiq_qual_check.sv
// Checker for the input qualifier: snoops both channels and the register port, predicts, compares.
`timescale 1ns / 1ps

module ebiq_qual_check #(
  parameter int TICK_W = ebiq_pkg::TICK_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ebiq_in_if                              in_mon,
  ebiq_out_if                             out_mon,
  input  logic                            cfg_we,
  input  logic [ebiq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ebiq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fails,
  output int                              pending
);
  import ebiq_pkg::*;

  localparam int TICK_HI = (1 << (TICK_W - 1)) - 1;
  localparam int TICK_LO = -TICK_HI - 1;

  // tick delta indexed by {prev_a, prev_b, a, b}
  int quad_delta [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

  // register shadows
  logic [31:0] idle_limit;
  logic [3:0]  detent_cfg;
  logic [15:0] dead_cfg;
  logic [15:0] bounce_cfg;
  logic [15:0] hold_cfg;

  // predicted block state
  logic [1:0]  ab_last;
  int          ticks;
  int          accum;
  logic [31:0] t_scroll, t_act, t_click, t_side, t_hold;
  bit          asleep, woke, running, click_was, side_was, holding, pwr_done;

  out_word_t   due_events [$];
  int          miss_count = 0;
  int          due_n = 0;
  int          words_seen = 0;

  assign fails   = miss_count;
  assign pending = due_n;

  task automatic flag_mismatch(string what);
    miss_count++;
    $display("[%0t] %s", $time, what);
  endtask

  function automatic logic [31:0] since(logic [31:0] now, logic [31:0] then);
    return now - then;
  endfunction

  function automatic string field_tag(int i);
    case (i)
      8: return "changed";
      7: return "scroll_down";
      6: return "scroll_up";
      5: return "enter";
      4: return "back";
      3: return "sleep_display";
      2: return "wake_display";
      1: return "power_off";
      default: return "woke_flag";
    endcase
  endfunction

  // Work out the result word for one command word; updates the predicted state.
  function automatic out_word_t qualify(in_word_t w);
    out_word_t   r;
    int          det;
    int          t;
    logic [31:0] now;
    r = '0;
    now = w.now_ms;
    case (w.opcode)
      OP_PIN: begin
        if (running) begin
          t = ticks + quad_delta[{ab_last, w.pin_a, w.pin_b}];
          if (t > TICK_HI) t = TICK_HI;
          if (t < TICK_LO) t = TICK_LO;
          ticks = t;
          ab_last = {w.pin_a, w.pin_b};
        end
      end
      OP_POLL: begin
        det = (detent_cfg == 4'd0) ? 1 : int'(detent_cfg);
        if (!running) begin
          t_act = now;
          running = 1'b1;
        end
        if (idle_limit != 32'd0 && !asleep && since(now, t_act) >= idle_limit) begin
          asleep = 1'b1;
          r.sleep_display = 1'b1;
        end
        accum += ticks;
        ticks = 0;
        if (accum >= det || accum <= -det) begin
          if (since(now, t_scroll) >= 32'(dead_cfg)) begin
            t_act = now;
            t_scroll = now;
            // first detent after sleep only wakes, rest of the poll is skipped
            if (asleep) begin
              asleep = 1'b0;
              woke = 1'b1;
              accum = 0;
              r.wake_display = 1'b1;
              return r;
            end
            r.changed = 1'b1;
            if (accum > 0) r.scroll_down = 1'b1;
            else r.scroll_up = 1'b1;
          end
          accum = 0;
        end
        if (!w.click_level && click_was && since(now, t_click) > 32'(bounce_cfg)) begin
          t_click = now;
          t_act = now;
          if (!asleep) begin
            r.changed = 1'b1;
            r.enter = 1'b1;
          end else begin
            asleep = 1'b0;
            woke = 1'b1;
            r.wake_display = 1'b1;
          end
        end
        click_was = w.click_level;
        if (!w.side_level && side_was && since(now, t_side) > 32'(bounce_cfg)) begin
          t_side = now;
          t_hold = now;
          holding = 1'b1;
          pwr_done = 1'b0;
          t_act = now;
          if (!asleep) begin
            r.changed = 1'b1;
            r.back = 1'b1;
          end else begin
            asleep = 1'b0;
            woke = 1'b1;
            r.wake_display = 1'b1;
          end
        end
        if (!w.side_level && !pwr_done && holding &&
            since(now, t_hold) >= 32'(hold_cfg)) begin
          pwr_done = 1'b1;
          r.power_off = 1'b1;
        end
        if (w.side_level) begin
          holding = 1'b0;
          pwr_done = 1'b0;
        end
        side_was = w.side_level;
      end
      OP_ACT: begin
        t_act = now;
        if (asleep) begin
          asleep = 1'b0;
          r.wake_display = 1'b1;
        end
      end
      default: begin
        r.woke_flag = woke;
        woke = 1'b0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    logic [8:0] got;
    logic [8:0] want;
    int         i;
    if (!rst_n) begin
      idle_limit = SLEEP_TIMEOUT_RST;
      detent_cfg = DETENT_RST;
      dead_cfg   = SCROLL_DEAD_RST;
      bounce_cfg = DEBOUNCE_RST;
      hold_cfg   = LONG_PRESS_RST;
      ab_last    = PREV_AB_RST;
      ticks      = 0;
      accum      = 0;
      t_scroll   = '0;
      t_act      = '0;
      t_click    = '0;
      t_side     = '0;
      t_hold     = '0;
      asleep     = 1'b0;
      woke       = 1'b0;
      running    = 1'b0;
      click_was  = 1'b1;
      side_was   = 1'b1;
      holding    = 1'b0;
      pwr_done   = 1'b0;
      due_events.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        words_seen++;
        if (due_events.size() == 0) begin
          flag_mismatch($sformatf("result word %0d with nothing due", words_seen));
        end else begin
          got = out_mon.data;
          want = due_events.pop_front();
          for (i = 8; i >= 0; i--) begin
            if (got[i] !== want[i])
              flag_mismatch($sformatf("result word %0d: %s is %b, predicted %b",
                                      words_seen, field_tag(i), got[i], want[i]));
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLEEP_TIMEOUT: idle_limit = cfg_wdata;
          CFG_DETENT:        detent_cfg = cfg_wdata[3:0];
          CFG_SCROLL_DEAD:   dead_cfg   = cfg_wdata[15:0];
          CFG_DEBOUNCE:      bounce_cfg = cfg_wdata[15:0];
          CFG_LONG_PRESS:    hold_cfg   = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) due_events.push_back(qualify(in_mon.data));
    end
    due_n = due_events.size();
  end

endmodule

// File: test/tb_top.sv
// Testbench top: clock, reset, command stimulus, result back-pressure and the verdict.
`timescale 1ns / 1ps

module tb_top;
  import ebiq_pkg::*;

  // Run shape: two directed passes, a long tick run each way, then random sets,
  // each set under its own register values.
  localparam int CYCLE_LIMIT   = 10_000_000;
  localparam int N_SETS        = 8;
  localparam int WORDS_PER_SET = 200;
  localparam int SAT_STEPS     = 150;     // many ticks folded by a single poll
  localparam int LONG_HOLD     = 400;     // receiver hold-off, fills the block

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ebiq_in_if  in_ch ();
  ebiq_out_if out_ch ();

  int fail_count;
  int due_count;
  int cyc = 0;

  // stimulus-side trackers
  logic [31:0] ms_now = '0;
  logic [1:0]  enc_ab = PREV_AB_RST;
  bit          cw = 1'b1;
  bit          click_lvl = 1'b1;
  bit          side_lvl = 1'b1;
  bit          steady_send = 1'b0;
  bit          hold_off = 1'b0;

  encoder_button_input_qualifier_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ebiq_qual_check qual_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fails     (fail_count),
    .pending   (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("encoder_button_input_qualifier_top: mismatch");
      $finish;
    end
  end

  // mostly short idles, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // next encoder level pair, one quadrature step forward (cw) or back
  function automatic logic [1:0] next_ab(logic [1:0] ab, bit fwd);
    case (ab)
      2'd3:    return fwd ? 2'd1 : 2'd2;
      2'd1:    return fwd ? 2'd0 : 2'd3;
      2'd0:    return fwd ? 2'd2 : 2'd1;
      default: return fwd ? 2'd3 : 2'd0;
    endcase
  endfunction

  // command word with the unused fields randomized
  function automatic in_word_t fill_word(logic [1:0] op, logic [31:0] ms);
    in_word_t w;
    w.opcode      = op;
    w.pin_a       = 1'($urandom_range(0, 1));
    w.pin_b       = 1'($urandom_range(0, 1));
    w.click_level = 1'($urandom_range(0, 1));
    w.side_level  = 1'($urandom_range(0, 1));
    w.now_ms      = ms;
    return w;
  endfunction

  // Offer one word; called and returns at a falling edge. valid stays up
  // after acceptance so back-to-back words need no extra assignment.
  task automatic send_word(in_word_t w);
    int gap;
    gap = (steady_send || $urandom_range(0, 99) < 65) ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.data  <= w;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering and wait until every predicted result word has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic program_regs(logic [31:0] idle, logic [3:0] det, logic [15:0] dead,
                              logic [15:0] bounce, logic [15:0] hold);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLEEP_TIMEOUT;
    cfg_wdata <= idle;
    @(negedge clk);
    cfg_index <= CFG_DETENT;
    cfg_wdata <= 32'(det);
    @(negedge clk);
    cfg_index <= CFG_SCROLL_DEAD;
    cfg_wdata <= 32'(dead);
    @(negedge clk);
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= 32'(bounce);
    @(negedge clk);
    cfg_index <= CFG_LONG_PRESS;
    cfg_wdata <= 32'(hold);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic do_pin(logic [1:0] ab);
    in_word_t w;
    w = fill_word(OP_PIN, ms_now);
    {w.pin_a, w.pin_b} = ab;
    enc_ab = ab;
    send_word(w);
  endtask

  task automatic spin(int n, bit fwd);
    repeat (n) do_pin(next_ab(enc_ab, fwd));
  endtask

  task automatic do_poll(logic [31:0] ms, bit click, bit side);
    in_word_t w;
    ms_now = ms;
    w = fill_word(OP_POLL, ms);
    w.click_level = click;
    w.side_level  = side;
    send_word(w);
  endtask

  task automatic do_cmd(logic [1:0] op, logic [31:0] ms);
    ms_now = ms;
    send_word(fill_word(op, ms));
  endtask

  // Random word: mostly clean quadrature motion and key levels with run
  // lengths (so holds and debounce windows are hit), plus pin noise and
  // timestamp jumps that wrap the millisecond counter.
  task automatic random_word(output in_word_t w);
    int t;
    int r;
    t = $urandom_range(0, 99);
    if (t < 70)      ms_now += $urandom_range(0, 40);
    else if (t < 95) ms_now += $urandom_range(0, 2500);
    else if (t < 98) ms_now += $urandom_range(0, 200000);
    else             ms_now = $urandom();
    r = $urandom_range(0, 99);
    if (r < 45) begin
      w = fill_word(OP_PIN, ms_now);
      if ($urandom_range(0, 11) == 0) cw = ~cw;
      if ($urandom_range(0, 9) == 0) enc_ab = 2'($urandom_range(0, 3));
      else enc_ab = next_ab(enc_ab, cw);
      {w.pin_a, w.pin_b} = enc_ab;
    end else if (r < 80) begin
      w = fill_word(OP_POLL, ms_now);
      if ($urandom_range(0, 3) == 0) click_lvl = ~click_lvl;
      if ($urandom_range(0, 5) == 0) side_lvl = ~side_lvl;
      w.click_level = click_lvl;
      w.side_level  = side_lvl;
    end else if (r < 90) begin
      w = fill_word(OP_ACT, ms_now);
    end else begin
      w = fill_word(OP_WOKE, ms_now);
    end
  endtask

  // Result side: random ready gaps except in recurring gap-free windows,
  // and one long hold-off on request so the input side backs up.
  initial begin : result_drain
    int low;
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      low = 0;
      if (hold_off && !held) begin
        held = 1'b1;
        low = LONG_HOLD;
      end else if ((cyc / 3000) % 4 != 1 && $urandom_range(0, 3) == 0) begin
        low = idle_len();
      end
      if (low > 0) begin
        out_ch.ready <= 1'b0;
        repeat (low) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [31:0] idle;
    logic [3:0]  det;
    logic [15:0] dead;
    logic [15:0] bounce;
    logic [15:0] hold;
    in_word_t    w;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed, reset register values ----
    do_pin(2'd1);                     // before the first poll: ignored
    enc_ab = PREV_AB_RST;             // block still holds its reset pin state
    do_cmd(OP_WOKE, 32'd0);           // woke flag clear after reset
    do_poll(32'd1000, 1'b1, 1'b1);    // first poll starts the idle timer
    spin(4, 1'b1);
    do_poll(32'd1100, 1'b1, 1'b1);    // one detent clockwise
    spin(4, 1'b0);
    do_poll(32'd1120, 1'b1, 1'b1);    // inside scroll dead time: dropped
    do_poll(32'd1200, 1'b0, 1'b1);    // click press
    do_poll(32'd1230, 1'b1, 1'b1);
    do_poll(32'd1240, 1'b0, 1'b1);    // inside debounce: ignored
    do_poll(32'd1300, 1'b1, 1'b0);    // side press
    do_poll(32'd3300, 1'b1, 1'b0);    // held long enough: power off
    do_poll(32'd3400, 1'b1, 1'b1);
    do_poll(32'd63400, 1'b0, 1'b1);   // timeout and click wake in one poll
    do_cmd(OP_WOKE, 32'd63400);
    do_cmd(OP_WOKE, 32'd63400);
    do_poll(32'd200000, 1'b1, 1'b1);  // idle sleep
    do_cmd(OP_ACT, 32'd200010);       // activity wakes, no woke flag
    do_cmd(OP_WOKE, 32'd200010);
    do_poll(32'd400000, 1'b1, 1'b1);  // sleep again
    spin(4, 1'b1);
    do_poll(32'd400100, 1'b1, 1'b1);  // detent while asleep only wakes
    do_cmd(OP_WOKE, 32'd400100);
    // side press at timestamp zero, reached through a counter wrap
    do_poll(32'hFFFF_FF00, 1'b1, 1'b0);
    do_poll(32'hFFFF_FF10, 1'b1, 1'b1);
    do_poll(32'd0, 1'b1, 1'b0);
    do_poll(32'd2000, 1'b1, 1'b0);
    do_poll(32'd2100, 1'b1, 1'b1);
    drain();

    // ---- directed, zero detent and zero long press ----
    program_regs(SLEEP_TIMEOUT_RST, 4'd0, SCROLL_DEAD_RST, DEBOUNCE_RST, 16'd0);
    spin(1, 1'b1);
    do_poll(32'd2200, 1'b1, 1'b1);    // single tick makes a detent
    do_poll(32'd2300, 1'b1, 1'b0);    // press and power off together
    do_poll(32'd2400, 1'b1, 1'b1);
    drain();

    // ---- long tick runs, both directions ----
    steady_send = 1'b1;
    spin(SAT_STEPS + $urandom_range(0, 20), 1'b1);
    do_poll(ms_now + 32'd100, 1'b1, 1'b1);
    spin(SAT_STEPS + $urandom_range(0, 20), 1'b0);
    do_poll(ms_now + 32'd100, 1'b1, 1'b1);
    steady_send = 1'b0;
    drain();

    // ---- random sets ----
    for (int p = 0; p < N_SETS; p++) begin
      case (p)
        0: begin
          idle = '0; det = 4'd15; dead = '0; bounce = '0; hold = 16'd1;
        end
        1: begin
          idle = 32'hFFFF_FFFF; det = 4'd1; dead = 16'hFFFF; bounce = 16'hFFFF;
          hold = 16'hFFFF;
        end
        2: begin
          idle = 32'd1; det = 4'd0; dead = '0; bounce = '0; hold = '0;
        end
        default: begin
          idle   = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(20, 3000));
          det    = 4'($urandom_range(0, 15));
          dead   = 16'($urandom_range(0, 120));
          bounce = 16'($urandom_range(0, 120));
          hold   = 16'($urandom_range(0, 800));
        end
      endcase
      program_regs(idle, det, dead, bounce, hold);
      steady_send = (p % 4 == 3);
      if (p == 0) hold_off = 1'b1;   // receiver stalls while words keep coming
      for (int i = 0; i < WORDS_PER_SET; i++) begin
        random_word(w);
        send_word(w);
      end
      drain();
    end

    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("encoder_button_input_qualifier_top: match");
    end else begin
      $display("encoder_button_input_qualifier_top: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/ebiq_pkg.sv
sv/ebiq_if.sv
sv/encoder_button_input_qualifier_top.sv
test/ebiq_qual_check.sv
test/tb_top.sv
